// ===== design/calendar_date_to_microsecond_timestamp_top_macros.svh =====
// Assertion macros for the calendar-to-timestamp top level.
`ifndef CALENDAR_DATE_TO_MICROSECOND_TIMESTAMP_TOP_MACROS_SVH
`define CALENDAR_DATE_TO_MICROSECOND_TIMESTAMP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CDTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CDTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CDTS_ASSERT(lbl, prop, msg)
`define CDTS_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== design/cdts_pkg.sv =====
// Shared types, constants and the month table for the timestamp pipeline.
package cdts_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_YEAR  = 2'd1,
        ST_BAD_MONTH = 2'd2,
        ST_BAD_DAY   = 2'd3
    } t_status;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_ctl;

    localparam int DAYS_W = 28;
    localparam int SECS_W = 46;
    localparam int OFFS_W = 32;
    localparam int TS_W   = 64;

    // Day of the March-based year on which each month starts.
    function automatic logic [8:0] month_base(input logic [3:0] month);
        logic [8:0] base;
        base = 9'd0;
        case (month)
            4'd1:    base = 9'd306;
            4'd2:    base = 9'd337;
            4'd3:    base = 9'd0;
            4'd4:    base = 9'd31;
            4'd5:    base = 9'd61;
            4'd6:    base = 9'd92;
            4'd7:    base = 9'd122;
            4'd8:    base = 9'd153;
            4'd9:    base = 9'd184;
            4'd10:   base = 9'd214;
            4'd11:   base = 9'd245;
            4'd12:   base = 9'd275;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

// ===== design/calendar_date_to_microsecond_timestamp_top.sv =====
// Top level: calendar date plus offsets to a microsecond timestamp.
//
//   Channel   Handshake            Payload
//   input     i_start / o_busy     i_year, i_month, i_day_of_month, five offsets
//   result    o_done (one cycle)   o_timestamp_us, o_status
//
// One item may enter every cycle; o_busy stays low.
// The result is set by six register stages (date arithmetic, with the hour and
// minute scaling alongside, in the first three; the day, millisecond and
// microsecond scaling in the last three).
// Synchronous reset clears the valid bits of all stages; items in flight are dropped.
// The receiver cannot stall, so nothing holds the pipeline.
`include "calendar_date_to_microsecond_timestamp_top_macros.svh"

module calendar_date_to_microsecond_timestamp_top import cdts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_year,
    input  logic [3:0]         i_month,
    input  logic [4:0]         i_day_of_month,
    input  logic signed [31:0] i_hour_offset,
    input  logic signed [31:0] i_minute_offset,
    input  logic signed [31:0] i_second_offset,
    input  logic signed [31:0] i_milli_offset,
    input  logic signed [31:0] i_micro_offset,
    output logic               o_done,
    output logic signed [63:0] o_timestamp_us,
    output logic [1:0]         o_status
);

    t_ctl              days_ctl;
    t_ctl              out_ctl;
    logic [DAYS_W-1:0] days;
    logic [SECS_W-1:0] secs;
    logic [OFFS_W-1:0] ms;
    logic [OFFS_W-1:0] us;
    logic [TS_W-1:0]   ts;

    assign o_busy = 1'b0;

    cdts_days u_days (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_start),
        .i_year         (i_year),
        .i_month        (i_month),
        .i_day_of_month (i_day_of_month),
        .o_ctl          (days_ctl),
        .o_days         (days)
    );

    cdts_offs u_offs (
        .i_clk           (i_clk),
        .i_hour_offset   (i_hour_offset),
        .i_minute_offset (i_minute_offset),
        .i_second_offset (i_second_offset),
        .i_milli_offset  (i_milli_offset),
        .i_micro_offset  (i_micro_offset),
        .o_secs          (secs),
        .o_ms            (ms),
        .o_us            (us)
    );

    cdts_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (days_ctl),
        .i_days         (days),
        .i_secs         (secs),
        .i_ms           (ms),
        .i_us           (us),
        .o_ctl          (out_ctl),
        .o_timestamp_us (ts)
    );

    assign o_done         = out_ctl.valid;
    assign o_status       = out_ctl.status;
    assign o_timestamp_us = ts;

    `CDTS_ASSERT_IMP(a_latency, i_start && !o_busy, ##6 o_done, "item lost in pipeline")
    `CDTS_ASSERT_IMP(a_no_extra, o_done, $past(i_start, 6), "result without an item")
    `CDTS_ASSERT_IMP(a_bad_zero, o_done && o_status != ST_OK, o_timestamp_us == 64'sd0,
        "invalid item gave a nonzero timestamp")
    `CDTS_ASSERT_IMP(a_bad_year, o_done && o_status == ST_BAD_YEAR,
        $past(i_year, 6) == 16'sh8000, "bad year status without the invalid year")

endmodule

// ===== design/cdts_days.sv =====
// Three-stage date check and days-from-civil day count.
module cdts_days import cdts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_year,
    input  logic [3:0]        i_month,
    input  logic [4:0]        i_day_of_month,
    output t_ctl              o_ctl,
    output logic [DAYS_W-1:0] o_days
);

    // Stage 1 signals.
    logic              month_le2;
    logic [17:0]       ysum;
    logic [24:0]       qprod;
    t_status           n1_status;
    t_ctl              r1_ctl;
    logic [16:0]       r1_ypos;
    logic [8:0]        r1_q;
    logic [8:0]        r1_doy;

    // Stage 2 signals.
    logic [16:0]       yrem;
    logic [9:0]        era;
    t_ctl              r2_ctl;
    logic [8:0]        r2_yoe;
    logic [DAYS_W-1:0] r2_era_days;
    logic [8:0]        r2_doy;

    // Stage 3 signals.
    logic [18:0]       y365;
    logic [13:0]       c41;
    logic [18:0]       doe;
    t_ctl              r3_ctl;
    logic [DAYS_W-1:0] r3_days;

    // The year is offset by 82 eras so the floor division works on a positive value.
    always_comb begin
        month_le2 = (i_month <= 4'd2);
        ysum      = {{2{i_year[15]}}, i_year} + 18'd32800 - 18'(month_le2);
        qprod     = 25'(ysum[16:4]) * 25'd2622;
        if (i_year == 16'h8000) begin
            n1_status = ST_BAD_YEAR;
        end else if (i_month == 4'd0 || i_month > 4'd12) begin
            n1_status = ST_BAD_MONTH;
        end else if (i_day_of_month == 5'd0) begin
            n1_status = ST_BAD_DAY;
        end else begin
            n1_status = ST_OK;
        end
    end

    always_comb begin
        yrem = r1_ypos - 17'(r1_q) * 17'd400;
        era  = {1'b0, r1_q} - 10'd82;
    end

    always_comb begin
        y365 = 19'(r2_yoe) * 19'd365;
        c41  = 14'(r2_yoe) * 14'd41;
        doe  = y365 + 19'(r2_yoe[8:2]) - 19'(c41[13:12]) + 19'(r2_doy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else begin
            r1_ctl <= '{valid: i_valid, status: n1_status};
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ypos     <= ysum[16:0];
        r1_q        <= qprod[24:16];
        r1_doy      <= month_base(i_month) + 9'(i_day_of_month) - 9'd1;
        r2_yoe      <= yrem[8:0];
        r2_era_days <= {{(DAYS_W-10){era[9]}}, era} * DAYS_W'(146097);
        r2_doy      <= r1_doy;
        r3_days     <= r2_era_days + DAYS_W'(doe) - DAYS_W'(719468);
    end

    assign o_ctl  = r3_ctl;
    assign o_days = r3_days;

endmodule

// ===== design/cdts_offs.sv =====
// Three-stage scaling of the hour and minute offsets into seconds.
module cdts_offs import cdts_pkg::*; (
    input  logic              i_clk,
    input  logic [OFFS_W-1:0] i_hour_offset,
    input  logic [OFFS_W-1:0] i_minute_offset,
    input  logic [OFFS_W-1:0] i_second_offset,
    input  logic [OFFS_W-1:0] i_milli_offset,
    input  logic [OFFS_W-1:0] i_micro_offset,
    output logic [SECS_W-1:0] o_secs,
    output logic [OFFS_W-1:0] o_ms,
    output logic [OFFS_W-1:0] o_us
);

    logic [43:0]       r1_hp;
    logic [37:0]       r1_mp;
    logic [OFFS_W-1:0] r1_s;
    logic [OFFS_W-1:0] r1_ms;
    logic [OFFS_W-1:0] r1_us;
    logic [SECS_W-1:0] r2_secs;
    logic [OFFS_W-1:0] r2_ms;
    logic [OFFS_W-1:0] r2_us;
    logic [SECS_W-1:0] r3_secs;
    logic [OFFS_W-1:0] r3_ms;
    logic [OFFS_W-1:0] r3_us;

    // The third stage only keeps these values in step with the day count.
    always_ff @(posedge i_clk) begin
        r1_hp   <= {{12{i_hour_offset[OFFS_W-1]}}, i_hour_offset} * 44'd3600;
        r1_mp   <= {{6{i_minute_offset[OFFS_W-1]}}, i_minute_offset} * 38'd60;
        r1_s    <= i_second_offset;
        r1_ms   <= i_milli_offset;
        r1_us   <= i_micro_offset;
        r2_secs <= {{2{r1_hp[43]}}, r1_hp} + {{8{r1_mp[37]}}, r1_mp}
                   + {{(SECS_W-OFFS_W){r1_s[OFFS_W-1]}}, r1_s};
        r2_ms   <= r1_ms;
        r2_us   <= r1_us;
        r3_secs <= r2_secs;
        r3_ms   <= r2_ms;
        r3_us   <= r2_us;
    end

    assign o_secs = r3_secs;
    assign o_ms   = r3_ms;
    assign o_us   = r3_us;

endmodule

// ===== design/cdts_scale.sv =====
// Three-stage merge of days and offsets into microseconds.
module cdts_scale import cdts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [DAYS_W-1:0] i_days,
    input  logic [SECS_W-1:0] i_secs,
    input  logic [OFFS_W-1:0] i_ms,
    input  logic [OFFS_W-1:0] i_us,
    output t_ctl              o_ctl,
    output logic [TS_W-1:0]   o_timestamp_us
);

    logic [47:0]       n4_dsec;
    logic [59:0]       n5_msum;
    logic [TS_W-1:0]   n6_usum;
    t_ctl              r4_ctl;
    t_ctl              r5_ctl;
    t_ctl              r6_ctl;
    logic [47:0]       r4_dsec;
    logic [OFFS_W-1:0] r4_ms;
    logic [OFFS_W-1:0] r4_us;
    logic [59:0]       r5_msum;
    logic [OFFS_W-1:0] r5_us;
    logic [TS_W-1:0]   r6_ts;

    // Every partial sum fits its width; only the last one wraps modulo 2^64.
    always_comb begin
        n4_dsec = {{(48-DAYS_W){i_days[DAYS_W-1]}}, i_days} * 48'd86400
                  + {{(48-SECS_W){i_secs[SECS_W-1]}}, i_secs};
        n5_msum = {{12{r4_dsec[47]}}, r4_dsec} * 60'd1000
                  + {{(60-OFFS_W){r4_ms[OFFS_W-1]}}, r4_ms};
        n6_usum = {{(TS_W-60){r5_msum[59]}}, r5_msum} * 64'd1000
                  + {{(TS_W-OFFS_W){r5_us[OFFS_W-1]}}, r5_us};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
            r5_ctl <= '0;
            r6_ctl <= '0;
        end else begin
            r4_ctl <= i_ctl;
            r5_ctl <= r4_ctl;
            r6_ctl <= r5_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_dsec <= n4_dsec;
        r4_ms   <= i_ms;
        r4_us   <= i_us;
        r5_msum <= n5_msum;
        r5_us   <= r4_us;
        r6_ts   <= (r5_ctl.status == ST_OK) ? n6_usum : '0;
    end

    assign o_ctl          = r6_ctl;
    assign o_timestamp_us = r6_ts;

endmodule
